// ===== src/mssp_pkg.sv =====
// Package with the shared constants, codes and types of the shared-pool multi-stack block.
`timescale 1ns / 1ps

package mssp_pkg;

    // Build size of the block.
    localparam int NUM_STACKS  = 4;
    localparam int POOL_SLOTS  = 16;
    localparam int QUEUE_DEPTH = 2;

    // Field widths fixed by the interface.
    localparam int ID_W    = 2;
    localparam int VALUE_W = 32;

    // Derived widths. A link holds a slot index or the null code POOL_SLOTS.
    localparam int SLOT_W   = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int LINK_W   = $clog2(POOL_SLOTS + 1);
    localparam int HEAD_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCOUNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_SLOTS);

    // Operation codes.
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_STACK = 2'd3
    } t_status;

    // One classified operation as it travels from the front to the back.
    typedef struct packed {
        logic                mode;
        logic [ID_W-1:0]     stack_id;
        logic [VALUE_W-1:0]  value;
        logic                bad_stack;
    } t_op;

    // Handshake between the front queue and the back end.
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_out;

endpackage

// ===== src/multi_stack_shared_pool_top.sv =====
// Top level of the multi-stack block whose stacks share one linked pool of slots.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  --------------------------------
// input     in         i_valid / o_ready    i_mode, i_stack_id, i_value
// result    out        o_valid / i_ready    o_status, o_pop_value
//
// Each operation passes the back end in S_ISSUE, which reads the link and data
// RAMs at the slot picked by the head registers, then S_COMMIT, which writes the
// link back and updates the heads; no new operation is taken before the last
// commits. Through an empty queue an input is queued, taken and then registered
// as a result at commit. Reset is synchronous and needs no clearing pass: a fill
// count stands in for the reset chain of the link RAM. A stalled result holds
// the back end while the two-entry queue keeps taking input until it is full.

module multi_stack_shared_pool_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_mode,
    input  logic [mssp_pkg::ID_W-1:0]           i_stack_id,
    input  logic signed [mssp_pkg::VALUE_W-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic signed [mssp_pkg::VALUE_W-1:0] o_pop_value
);

    // Queue head as seen by the back end, and the back end's pop request.
    mssp_pkg::t_q_out q_out;
    logic             q_pop;

    // The front flags stack numbers beyond the built range and queues each
    // operation so that input transfers continue while the back end works.
    mssp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_stack_id (i_stack_id),
        .i_value    (i_value),
        .o_q        (q_out),
        .i_q_pop    (q_pop)
    );

    // The back end owns the head registers, the free list and the pool RAMs,
    // and holds each result in an output register until it is transferred.
    mssp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q_out),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_pop_value (o_pop_value)
    );

endmodule

// ===== src/mssp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module mssp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds until the next read is issued.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mssp_front.sv =====
// Front end: takes input transfers, flags bad stack numbers and queues the operations.
`timescale 1ns / 1ps

module mssp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_mode,
    input  logic [mssp_pkg::ID_W-1:0]           i_stack_id,
    input  logic signed [mssp_pkg::VALUE_W-1:0] i_value,
    output mssp_pkg::t_q_out                    o_q,
    input  logic                                i_q_pop
);

    mssp_pkg::t_op                     r_entry [mssp_pkg::QUEUE_DEPTH];
    logic [mssp_pkg::QPTR_W-1:0]       r_wptr;
    logic [mssp_pkg::QPTR_W-1:0]       r_rptr;
    logic [mssp_pkg::QCOUNT_W-1:0]     r_count;
    mssp_pkg::t_op                     in_op;
    logic                              push;
    logic                              pop;

    always_comb begin
        in_op.mode      = i_mode;
        in_op.stack_id  = i_stack_id;
        in_op.value     = i_value;
        in_op.bad_stack = (32'(i_stack_id) >= 32'(mssp_pkg::NUM_STACKS));
    end

    assign o_ready = (r_count != mssp_pkg::QCOUNT_W'(mssp_pkg::QUEUE_DEPTH));
    assign push    = i_valid && o_ready;
    assign pop     = i_q_pop && (r_count != '0);

    assign o_q.valid = (r_count != '0);
    assign o_q.op    = r_entry[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_entry[r_wptr] <= in_op;
                r_wptr <= (32'(r_wptr) == mssp_pkg::QUEUE_DEPTH - 1) ? '0
                                                                     : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (32'(r_rptr) == mssp_pkg::QUEUE_DEPTH - 1) ? '0
                                                                     : r_rptr + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/mssp_back.sv =====
// Back end: walks the free list and stack heads, updates the pool RAMs and drives results.
`timescale 1ns / 1ps

module mssp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mssp_pkg::t_q_out                    i_q,
    output logic                                o_q_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic signed [mssp_pkg::VALUE_W-1:0] o_pop_value
);

    typedef enum logic {
        S_ISSUE,
        S_COMMIT
    } t_state;

    localparam int SW = mssp_pkg::SLOT_W;
    localparam int LW = mssp_pkg::LINK_W;
    localparam int VW = mssp_pkg::VALUE_W;

    t_state                  r_state;
    logic [LW-1:0]           r_stack_head [mssp_pkg::NUM_STACKS];
    logic [LW-1:0]           r_free_head;
    logic [LW-1:0]           r_fill;       // slots at or above this were never allocated
    logic                    r_o_valid;
    mssp_pkg::t_status       r_o_status;
    logic [VW-1:0]           r_o_pop_value;

    mssp_pkg::t_op           r_op;
    mssp_pkg::t_status       r_status;
    logic [LW-1:0]           r_slot;
    logic                    r_fresh;

    logic [mssp_pkg::HEAD_W-1:0] in_idx;
    logic [mssp_pkg::HEAD_W-1:0] op_idx;
    logic [LW-1:0]           in_head;
    logic [LW-1:0]           slot_sel;
    mssp_pkg::t_status       status_sel;
    logic                    take;
    logic                    commit;
    logic                    commit_ok;
    logic [LW-1:0]           link_q;
    logic [LW-1:0]           link_rd;
    logic [VW-1:0]           data_q;
    logic                    link_we;
    logic [LW-1:0]           link_wdata;
    logic                    data_we;

    assign in_idx  = mssp_pkg::HEAD_W'(i_q.op.stack_id);
    assign op_idx  = mssp_pkg::HEAD_W'(r_op.stack_id);
    assign in_head = i_q.op.bad_stack ? mssp_pkg::LINK_NULL : r_stack_head[in_idx];

    always_comb begin
        slot_sel = (i_q.op.mode == mssp_pkg::MODE_PUSH) ? r_free_head : in_head;
        priority if (i_q.op.bad_stack) begin
            status_sel = mssp_pkg::ST_BAD_STACK;
        end else if (slot_sel >= mssp_pkg::LINK_NULL) begin
            status_sel = (i_q.op.mode == mssp_pkg::MODE_PUSH) ? mssp_pkg::ST_OVERFLOW
                                                               : mssp_pkg::ST_UNDERFLOW;
        end else begin
            status_sel = mssp_pkg::ST_OK;
        end
    end

    assign take      = (r_state == S_ISSUE) && i_q.valid;
    assign o_q_pop   = take;
    assign commit    = (r_state == S_COMMIT) && (!r_o_valid || i_ready);
    assign commit_ok = commit && (r_status == mssp_pkg::ST_OK);

    // A never-allocated slot is treated as holding its reset link to the next slot;
    // for the last slot that sum is the null code.
    assign link_rd = r_fresh ? (r_slot + LW'(1)) : link_q;

    always_comb begin
        link_we    = commit_ok;
        data_we    = commit_ok && (r_op.mode == mssp_pkg::MODE_PUSH);
        link_wdata = (r_op.mode == mssp_pkg::MODE_PUSH) ? r_stack_head[op_idx] : r_free_head;
    end

    mssp_ram #(
        .WIDTH (LW),
        .DEPTH (mssp_pkg::POOL_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_slot[SW-1:0]),
        .i_wdata (link_wdata),
        .i_re    (take),
        .i_raddr (slot_sel[SW-1:0]),
        .o_rdata (link_q)
    );

    mssp_ram #(
        .WIDTH (VW),
        .DEPTH (mssp_pkg::POOL_SLOTS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (r_slot[SW-1:0]),
        .i_wdata (r_op.value),
        .i_re    (take),
        .i_raddr (slot_sel[SW-1:0]),
        .o_rdata (data_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ISSUE;
            r_free_head <= '0;
            r_fill      <= '0;
            r_o_valid   <= 1'b0;
            for (int k = 0; k < mssp_pkg::NUM_STACKS; k++) begin
                r_stack_head[k] <= mssp_pkg::LINK_NULL;
            end
        end else begin
            // A commit in the same cycle loads the next result instead.
            if (r_o_valid && i_ready && !commit) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_ISSUE: begin
                    if (take) begin
                        r_op     <= i_q.op;
                        r_status <= status_sel;
                        r_slot   <= slot_sel;
                        r_fresh  <= (slot_sel >= r_fill);
                        r_state  <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (commit) begin
                        r_o_valid     <= 1'b1;
                        r_o_status    <= r_status;
                        r_o_pop_value <= '0;
                        if (commit_ok) begin
                            if (r_op.mode == mssp_pkg::MODE_PUSH) begin
                                r_free_head          <= link_rd;
                                r_stack_head[op_idx] <= r_slot;
                                if (r_fresh) begin
                                    r_fill <= r_fill + LW'(1);
                                end
                            end else begin
                                r_stack_head[op_idx] <= link_rd;
                                r_free_head          <= r_slot;
                                r_o_pop_value        <= data_q;
                            end
                        end
                        r_state <= S_ISSUE;
                    end
                end
                default: r_state <= S_ISSUE;
            endcase
        end
    end

    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_pop_value = r_o_pop_value;

endmodule
